FILE: design/atrfp_pkg.sv
// ---------------------------------------------------------------------------
// AT receive frame parser package
// Shared types, character constants and the prefix table of the parser.
// ---------------------------------------------------------------------------
`default_nettype none

package atrfp_pkg;

  localparam int unsigned DEF_MAX_FRAME_LENGTH = 65535;
  localparam logic [3:0]  MAX_LINK_ID_RESET    = 4'd4;

  localparam logic [2:0]  PREFIX_LAST = 3'd4;

  localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
  localparam logic [7:0]  CHAR_I     = 8'h49;
  localparam logic [7:0]  CHAR_P     = 8'h50;
  localparam logic [7:0]  CHAR_D     = 8'h44;
  localparam logic [7:0]  CHAR_COMMA = 8'h2C;
  localparam logic [7:0]  CHAR_COLON = 8'h3A;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_LINK,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  prefix_pos;
    logic [7:0]  link_accum;
    logic [15:0] length_accum;
    logic [15:0] bytes_left;
  } parse_state_t;

  typedef struct packed {
    logic       is_payload;
    logic [7:0] out_byte;
    logic [3:0] link_number;
    logic       last_of_frame;
    logic       header_done;
    logic       header_dropped;
  } parse_result_t;

  // Expected character at each position of the "+IPD," prefix.
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CHAR_PLUS;
      3'd1:    c = CHAR_I;
      3'd2:    c = CHAR_P;
      3'd3:    c = CHAR_D;
      3'd4:    c = CHAR_COMMA;
      default: c = CHAR_PLUS;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/atrfp_step.sv
// ---------------------------------------------------------------------------
// AT receive frame parser step logic
// Combinational next state and result for one received byte.
// ---------------------------------------------------------------------------
`default_nettype none

module atrfp_step #(
  parameter int unsigned MAX_FRAME_LENGTH = atrfp_pkg::DEF_MAX_FRAME_LENGTH
) (
  input  wire atrfp_pkg::parse_state_t  state_cur,
  input  wire logic [7:0]               rx_byte,
  input  wire logic [3:0]               max_link_id,
  output atrfp_pkg::parse_state_t       state_next,
  output atrfp_pkg::parse_result_t      result
);

  logic        digit;
  logic [3:0]  digit_val;
  logic [2:0]  pos;
  logic        prefix_hit;
  logic [7:0]  link_new;
  logic [19:0] len_wide;
  logic        len_over;

  always_comb begin
    digit     = (rx_byte >= atrfp_pkg::CHAR_ZERO) && (rx_byte <= atrfp_pkg::CHAR_NINE);
    digit_val = 4'(rx_byte - atrfp_pkg::CHAR_ZERO);
    // A position past the last prefix character restarts the match.
    pos        = (state_cur.prefix_pos <= atrfp_pkg::PREFIX_LAST) ? state_cur.prefix_pos : 3'd0;
    prefix_hit = (rx_byte == atrfp_pkg::prefix_char(pos));
    link_new   = {state_cur.link_accum[4:0], 3'b000} + {state_cur.link_accum[6:0], 1'b0}
               + {4'b0000, digit_val};
    len_wide   = {1'b0, state_cur.length_accum, 3'b000} + {3'b000, state_cur.length_accum, 1'b0}
               + {16'h0000, digit_val};
    len_over   = (len_wide > 20'(MAX_FRAME_LENGTH));
  end

  // Next state.
  always_comb begin
    state_next = state_cur;
    case (state_cur.phase)
      atrfp_pkg::PH_PAYLOAD: begin
        if (state_cur.bytes_left <= 16'd1) begin
          state_next.bytes_left = 16'd0;
          state_next.phase      = atrfp_pkg::PH_SEARCH;
        end else begin
          state_next.bytes_left = state_cur.bytes_left - 16'd1;
        end
      end
      atrfp_pkg::PH_SEARCH: begin
        if (prefix_hit) begin
          if (pos == atrfp_pkg::PREFIX_LAST) begin
            state_next.prefix_pos = 3'd0;
            state_next.link_accum = 8'd0;
            state_next.phase      = atrfp_pkg::PH_LINK;
          end else begin
            state_next.prefix_pos = pos + 3'd1;
          end
        end else begin
          state_next.prefix_pos = (rx_byte == atrfp_pkg::CHAR_PLUS) ? 3'd1 : 3'd0;
        end
      end
      atrfp_pkg::PH_LINK: begin
        if (digit) begin
          state_next.link_accum = link_new;
          if (link_new > {4'b0000, max_link_id}) begin
            state_next.phase = atrfp_pkg::PH_SEARCH;
          end
        end else if (rx_byte == atrfp_pkg::CHAR_COMMA) begin
          state_next.length_accum = 16'd0;
          state_next.phase        = atrfp_pkg::PH_LENGTH;
        end else begin
          state_next.phase = atrfp_pkg::PH_SEARCH;
        end
      end
      atrfp_pkg::PH_LENGTH: begin
        if (digit) begin
          state_next.length_accum = len_wide[15:0];
          if (len_over) begin
            state_next.phase = atrfp_pkg::PH_SEARCH;
          end
        end else if (rx_byte == atrfp_pkg::CHAR_COLON && state_cur.length_accum != 16'd0) begin
          state_next.bytes_left = state_cur.length_accum;
          state_next.phase      = atrfp_pkg::PH_PAYLOAD;
        end else begin
          state_next.phase = atrfp_pkg::PH_SEARCH;
        end
      end
      default: begin
        state_next = state_cur;
      end
    endcase
  end

  // Result for this byte.
  always_comb begin
    result          = '0;
    result.out_byte = rx_byte;
    case (state_cur.phase)
      atrfp_pkg::PH_PAYLOAD: begin
        result.is_payload    = 1'b1;
        result.link_number   = state_cur.link_accum[3:0];
        result.last_of_frame = (state_cur.bytes_left <= 16'd1);
      end
      atrfp_pkg::PH_SEARCH: begin
        result.header_dropped = 1'b0;
      end
      atrfp_pkg::PH_LINK: begin
        if (digit) begin
          result.header_dropped = (link_new > {4'b0000, max_link_id});
        end else begin
          result.header_dropped = (rx_byte != atrfp_pkg::CHAR_COMMA);
        end
      end
      atrfp_pkg::PH_LENGTH: begin
        if (digit) begin
          result.header_dropped = len_over;
        end else if (rx_byte == atrfp_pkg::CHAR_COLON && state_cur.length_accum != 16'd0) begin
          result.header_done = 1'b1;
        end else begin
          result.header_dropped = 1'b1;
        end
      end
      default: begin
        result.header_dropped = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/at_receive_frame_parser_core.sv
// ---------------------------------------------------------------------------
// AT receive frame parser
// Splits a modem receive byte stream into "+IPD," frame payload and
// response-path bytes.
// ---------------------------------------------------------------------------
// The block takes one byte per clock and returns one tagged byte per clock
// while the output side keeps taking results: the byte is captured in an
// input register, the parser state and the result are computed from it
// combinationally, and the result waits in an output register. The parser
// state update is the only loop, so a new byte can be accepted every
// cycle while the output side keeps taking results. The max_link_id register
// resets to 4 and should be written only while no transaction is in flight.
`default_nettype none

module at_receive_frame_parser_core #(
  parameter int unsigned MAX_FRAME_LENGTH = atrfp_pkg::DEF_MAX_FRAME_LENGTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: max_link_id.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_byte, [11:8] link_number, [15:12] zero
  output logic [2:0]       m_tuser,   // [0] is_payload, [1] header_done, [2] header_dropped
  output logic             m_tlast    // last_of_frame
);

  logic                    in_valid;
  logic [7:0]              in_byte;
  logic [3:0]              max_link_id;
  atrfp_pkg::parse_state_t state;
  atrfp_pkg::parse_state_t state_next;
  atrfp_pkg::parse_result_t step_result;
  atrfp_pkg::parse_result_t out_result;
  logic                    out_free;
  logic                    advance;

  assign out_free  = !m_tvalid || m_tready;
  assign advance   = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;
  assign cfg_ready = 1'b1;

  atrfp_step #(
    .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
  ) u_step (
    .state_cur   (state),
    .rx_byte     (in_byte),
    .max_link_id (max_link_id),
    .state_next  (state_next),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_link_id <= atrfp_pkg::MAX_LINK_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_link_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {4'b0000, out_result.link_number, out_result.out_byte};
  assign m_tuser = {out_result.header_dropped, out_result.header_done, out_result.is_payload};
  assign m_tlast = out_result.last_of_frame;

endmodule

`default_nettype wire
